// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== src/ftes_pkg.sv =====
// Shared constants, types and helpers for the triangle edge span setup
package ftes_pkg;

  localparam int ROWS     = 8;
  localparam int CNT_W    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int LANE_W   = 3;
  localparam int XW       = 12;
  localparam int CW       = 16;
  localparam int MAG_W    = 16;
  localparam int TY_W     = 18;
  localparam int Q_W      = 32;
  localparam int S_W      = 34;
  localparam int V_W      = 56;
  localparam int FRAC     = 20;
  localparam int QDEPTH   = 2;
  localparam int QPTR_W   = 1;
  localparam int DIV_STEP = 4;
  localparam int DIV_CYC  = Q_W / DIV_STEP;
  localparam int DCNT_W   = $clog2(DIV_CYC);
  localparam int CFG_IDX_W = 1;

  localparam logic [XW-1:0]        XMAX = '1;
  localparam logic [FRAC-1:0]      HALF = {1'b1, {(FRAC-1){1'b0}}};
  localparam logic [CFG_IDX_W-1:0] CFG_TILE_X = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TILE_Y = 1'b1;

  // One classified triangle waiting for the back end
  typedef struct packed {
    logic                   degen;
    logic                   last;
    logic signed [TY_W-1:0] ty;
    logic signed [TY_W-1:0] dxo;
    logic                   lneg;
    logic [MAG_W-1:0]       lnum;
    logic [MAG_W-1:0]       lden;
    logic                   rneg;
    logic [MAG_W-1:0]       rnum;
    logic [MAG_W-1:0]       rden;
  } item_t;

  // Round Q.20 to nearest, ties to even, clamp to 0..XMAX
  function automatic logic [XW-1:0] round_clamp(input logic signed [V_W-1:0] v);
    logic [V_W-FRAC-1:0] q;
    logic [FRAC-1:0]     r;
    logic                up;
    logic [V_W-FRAC:0]   qr;
    logic [XW-1:0]       res;
    q  = v[V_W-1:FRAC];
    r  = v[FRAC-1:0];
    up = (r > HALF) || ((r == HALF) && q[0]);
    qr = {1'b0, q} + {{(V_W-FRAC){1'b0}}, up};
    if (v <= 0) begin
      res = '0;
    end else if (qr > {{(V_W-FRAC+1-XW){1'b0}}, XMAX}) begin
      res = XMAX;
    end else begin
      res = qr[XW-1:0];
    end
    return res;
  endfunction

endpackage

// ===== src/ftes_front.sv =====
// Front end: tile registers, command transfer and triangle classification
module ftes_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [ftes_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [ftes_pkg::XW-1:0]           cfg_data_i,
  input  logic                              take_i,
  input  logic                              opcode_i,
  input  logic signed [ftes_pkg::CW-1:0]    ax_i,
  input  logic signed [ftes_pkg::CW-1:0]    ay_i,
  input  logic signed [ftes_pkg::CW-1:0]    bx_i,
  input  logic signed [ftes_pkg::CW-1:0]    by_i,
  input  logic signed [ftes_pkg::CW-1:0]    cx_i,
  input  logic signed [ftes_pkg::CW-1:0]    cy_i,
  input  logic                              last_triangle_i,
  output logic                              push_o,
  output ftes_pkg::item_t                   item_o
);

  typedef enum logic {OP_FLAT_BOTTOM, OP_FLAT_TOP} op_e;

  logic [ftes_pkg::XW-1:0] tile_x_q, tile_y_q;
  logic signed [ftes_pkg::CW:0]     ldx, ldy, rdx, rdy;
  logic signed [ftes_pkg::CW-1:0]   apx, apy;
  logic signed [ftes_pkg::CW:0]     ldx_m, ldy_m, rdx_m, rdy_m;
  logic signed [ftes_pkg::TY_W-1:0] tx;

  // Hold the tile origin registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tile_x_q <= '0;
      tile_y_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ftes_pkg::CFG_TILE_X: tile_x_q <= cfg_data_i;
        ftes_pkg::CFG_TILE_Y: tile_y_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Pick apex and edge deltas by triangle kind
  always_comb begin
    if (op_e'(opcode_i) == OP_FLAT_TOP) begin
      apx = cx_i;
      apy = cy_i;
      ldx = (ftes_pkg::CW+1)'(ax_i) - (ftes_pkg::CW+1)'(cx_i);
      ldy = (ftes_pkg::CW+1)'(ay_i) - (ftes_pkg::CW+1)'(cy_i);
      rdx = (ftes_pkg::CW+1)'(bx_i) - (ftes_pkg::CW+1)'(cx_i);
      rdy = (ftes_pkg::CW+1)'(by_i) - (ftes_pkg::CW+1)'(cy_i);
    end else begin
      apx = ax_i;
      apy = ay_i;
      ldx = (ftes_pkg::CW+1)'(bx_i) - (ftes_pkg::CW+1)'(ax_i);
      ldy = (ftes_pkg::CW+1)'(by_i) - (ftes_pkg::CW+1)'(ay_i);
      rdx = (ftes_pkg::CW+1)'(cx_i) - (ftes_pkg::CW+1)'(ax_i);
      rdy = (ftes_pkg::CW+1)'(cy_i) - (ftes_pkg::CW+1)'(ay_i);
    end
  end

  // Take magnitudes and tile offsets
  always_comb begin
    ldx_m = ldx[ftes_pkg::CW] ? -ldx : ldx;
    ldy_m = ldy[ftes_pkg::CW] ? -ldy : ldy;
    rdx_m = rdx[ftes_pkg::CW] ? -rdx : rdx;
    rdy_m = rdy[ftes_pkg::CW] ? -rdy : rdy;
    tx = $signed({2'b00, tile_x_q, 4'b0000}) - ftes_pkg::TY_W'(8);

    item_o.degen = (ldy == '0) || (rdy == '0);
    item_o.last  = last_triangle_i;
    item_o.ty    = $signed({2'b00, tile_y_q, 4'b1000}) - ftes_pkg::TY_W'(apy);
    item_o.dxo   = ftes_pkg::TY_W'(apx) - tx;
    item_o.lneg  = ldx[ftes_pkg::CW] ^ ldy[ftes_pkg::CW];
    item_o.lnum  = ldx_m[ftes_pkg::MAG_W-1:0];
    item_o.lden  = ldy_m[ftes_pkg::MAG_W-1:0];
    item_o.rneg  = rdx[ftes_pkg::CW] ^ rdy[ftes_pkg::CW];
    item_o.rnum  = rdx_m[ftes_pkg::MAG_W-1:0];
    item_o.rden  = rdy_m[ftes_pkg::MAG_W-1:0];
  end

  assign push_o = take_i;

endmodule

// ===== src/ftes_queue.sv =====
// Short queue between front and back end
module ftes_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ftes_pkg::item_t item_i,
  input  logic            pop_i,
  output logic            full_o,
  output logic            valid_o,
  output ftes_pkg::item_t item_o
);

  localparam int CNT_QW = $clog2(ftes_pkg::QDEPTH + 1);

  ftes_pkg::item_t                 mem_q [ftes_pkg::QDEPTH];
  logic [ftes_pkg::QPTR_W-1:0]     wr_q, rd_q;
  logic [CNT_QW-1:0]               cnt_q;

  assign full_o  = (cnt_q == CNT_QW'(ftes_pkg::QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_q];

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

// ===== src/ftes_div.sv =====
// Unsigned radix-16 restoring divider for |dx|*65536 / |dy|
module ftes_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        load_i,
  input  logic                        step_i,
  input  logic [ftes_pkg::MAG_W-1:0]  num_i,
  input  logic [ftes_pkg::MAG_W-1:0]  den_i,
  output logic                        last_o,
  output logic [ftes_pkg::Q_W-1:0]    quot_o
);

  logic [ftes_pkg::MAG_W:0]    rem_q, rem_d;
  logic [ftes_pkg::Q_W-1:0]    sh_q, sh_d;
  logic [ftes_pkg::MAG_W-1:0]  den_q;
  logic [ftes_pkg::DCNT_W-1:0] cnt_q;
  logic                        run_q;

  // Four quotient bits per cycle while step_i is high
  always_comb begin
    rem_d = rem_q;
    sh_d  = sh_q;
    for (int i = 0; i < ftes_pkg::DIV_STEP; i++) begin
      rem_d = {rem_d[ftes_pkg::MAG_W-1:0], sh_d[ftes_pkg::Q_W-1]};
      sh_d  = {sh_d[ftes_pkg::Q_W-2:0], 1'b0};
      if (rem_d >= {1'b0, den_q}) begin
        rem_d    = rem_d - {1'b0, den_q};
        sh_d[0]  = 1'b1;
      end
    end
  end

  assign last_o = run_q && (cnt_q == ftes_pkg::DCNT_W'(ftes_pkg::DIV_CYC - 1));
  assign quot_o = sh_d;

  // Load a new division or advance the current one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else if (load_i) begin
      run_q <= 1'b1;
      cnt_q <= '0;
    end else if (run_q && step_i) begin
      cnt_q <= cnt_q + 1'b1;
      if (last_o) run_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rem_q <= '0;
      sh_q  <= {num_i, {(ftes_pkg::Q_W-ftes_pkg::MAG_W){1'b0}}};
      den_q <= den_i;
    end else if (run_q && step_i) begin
      rem_q <= rem_d;
      sh_q  <= sh_d;
    end
  end

endmodule

// ===== src/ftes_back.sv =====
// Back end: slope division, start value products and lane walk
module ftes_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  input  ftes_pkg::item_t               q_item_i,
  output logic                          pop_o,
  output logic                          strobe_o,
  output logic [ftes_pkg::LANE_W-1:0]   lane_o,
  output logic [ftes_pkg::XW-1:0]       left_x_o,
  output logic [ftes_pkg::XW-1:0]       right_x_o,
  output logic                          degenerate_o,
  output logic                          last_lane_o,
  output logic                          batch_done_o
);

  typedef enum logic [1:0] {PH_MUL, PH_SUM, PH_DONE} ph_e;

  localparam int V_W = ftes_pkg::V_W;

  // Division stage
  logic                   d_v_q;
  ftes_pkg::item_t        d_item_q;
  logic                   l_last, r_last, hand_div, div_step;
  logic [ftes_pkg::Q_W-1:0] l_quot, r_quot;
  logic signed [ftes_pkg::S_W-1:0] l_s, r_s;

  // Product stage
  logic                            m_v_q, mul_free, hand_mul;
  ph_e                             m_ph_q;
  logic signed [ftes_pkg::S_W-1:0] m_sl_q, m_sr_q;
  logic signed [ftes_pkg::TY_W-1:0] m_ty_q, m_dxo_q;
  logic                            m_degen_q, m_last_q;
  logic signed [35:0]              m_pll_q, m_prl_q;
  logic signed [34:0]              m_plh_q, m_prh_q;
  logic signed [V_W-1:0]           m_bl_q, m_br_q, m_suml_q, m_sumr_q;

  // Lane stage
  logic                             e_v_q, emit_free, e_end;
  logic [ftes_pkg::CNT_W-1:0]       e_cnt_q;
  logic signed [V_W-1:0]            e_vl_q, e_vr_q, e_stl_q, e_str_q;
  logic                             e_degen_q, e_last_q;

  assign mul_free = !m_v_q || hand_mul;
  assign hand_div = d_v_q && l_last && r_last && mul_free;
  assign div_step = !l_last || mul_free;
  assign pop_o    = q_valid_i && (!d_v_q || hand_div);

  ftes_div u_div_l (
    .clk_i, .rst_ni,
    .load_i (pop_o),
    .step_i (div_step),
    .num_i  (q_item_i.lnum),
    .den_i  (q_item_i.lden),
    .last_o (l_last),
    .quot_o (l_quot)
  );

  ftes_div u_div_r (
    .clk_i, .rst_ni,
    .load_i (pop_o),
    .step_i (div_step),
    .num_i  (q_item_i.rnum),
    .den_i  (q_item_i.rden),
    .last_o (r_last),
    .quot_o (r_quot)
  );

  // Apply the slope signs
  always_comb begin
    l_s = $signed({2'b00, l_quot});
    r_s = $signed({2'b00, r_quot});
    if (d_item_q.lneg) l_s = -l_s;
    if (d_item_q.rneg) r_s = -r_s;
  end

  // Hold the item under division
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_v_q <= 1'b0;
    end else if (pop_o) begin
      d_v_q <= 1'b1;
    end else if (hand_div) begin
      d_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) d_item_q <= q_item_i;
  end

  // Product stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_v_q  <= 1'b0;
      m_ph_q <= PH_MUL;
    end else if (hand_div) begin
      m_v_q  <= 1'b1;
      m_ph_q <= PH_MUL;
    end else if (hand_mul) begin
      m_v_q  <= 1'b0;
    end else if (m_v_q) begin
      case (m_ph_q)
        PH_MUL:  m_ph_q <= PH_SUM;
        PH_SUM:  m_ph_q <= PH_DONE;
        default: m_ph_q <= PH_DONE;
      endcase
    end
  end

  // Split products of ty and slope, then combine with the base offset
  always_ff @(posedge clk_i) begin
    if (hand_div) begin
      m_sl_q    <= l_s;
      m_sr_q    <= r_s;
      m_ty_q    <= d_item_q.ty;
      m_dxo_q   <= d_item_q.dxo;
      m_degen_q <= d_item_q.degen;
      m_last_q  <= d_item_q.last;
    end
    if (m_v_q && (m_ph_q == PH_MUL)) begin
      m_pll_q <= m_ty_q * $signed({1'b0, m_sl_q[16:0]});
      m_plh_q <= m_ty_q * $signed(m_sl_q[ftes_pkg::S_W-1:17]);
      m_prl_q <= m_ty_q * $signed({1'b0, m_sr_q[16:0]});
      m_prh_q <= m_ty_q * $signed(m_sr_q[ftes_pkg::S_W-1:17]);
      m_bl_q  <= (V_W'(m_dxo_q) <<< 16)
               + ((V_W'(m_sl_q) * V_W'(ftes_pkg::ROWS - 1)) <<< 4);
      m_br_q  <= (V_W'(m_dxo_q) <<< 16)
               + ((V_W'(m_sr_q) * V_W'(ftes_pkg::ROWS - 1)) <<< 4);
    end
    if (m_v_q && (m_ph_q == PH_SUM)) begin
      m_suml_q <= (V_W'(m_plh_q) <<< 17) + V_W'(m_pll_q);
      m_sumr_q <= (V_W'(m_prh_q) <<< 17) + V_W'(m_prl_q);
    end
  end

  assign e_end     = (e_cnt_q == ftes_pkg::CNT_W'(ftes_pkg::ROWS - 1));
  assign emit_free = !e_v_q || e_end;
  assign hand_mul  = m_v_q && (m_ph_q == PH_DONE) && emit_free;

  // Lane walk control and registered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_v_q    <= 1'b0;
      e_cnt_q  <= '0;
      strobe_o <= 1'b0;
    end else begin
      strobe_o <= e_v_q;
      if (hand_mul) begin
        e_v_q   <= 1'b1;
        e_cnt_q <= '0;
      end else if (e_v_q) begin
        if (e_end) e_v_q <= 1'b0;
        e_cnt_q <= e_cnt_q + 1'b1;
      end
    end
  end

  // Step the edge values down one slope per lane
  always_ff @(posedge clk_i) begin
    if (hand_mul) begin
      e_vl_q    <= m_suml_q + m_bl_q;
      e_vr_q    <= m_sumr_q + m_br_q;
      e_stl_q   <= V_W'(m_sl_q) <<< 4;
      e_str_q   <= V_W'(m_sr_q) <<< 4;
      e_degen_q <= m_degen_q;
      e_last_q  <= m_last_q;
    end else if (e_v_q) begin
      e_vl_q <= e_vl_q - e_stl_q;
      e_vr_q <= e_vr_q - e_str_q;
    end
    if (e_v_q) begin
      lane_o       <= ftes_pkg::LANE_W'(e_cnt_q);
      left_x_o     <= e_degen_q ? '0 : ftes_pkg::round_clamp(e_vl_q);
      right_x_o    <= e_degen_q ? '0 : ftes_pkg::round_clamp(e_vr_q);
      degenerate_o <= e_degen_q;
      last_lane_o  <= e_end;
      batch_done_o <= e_end && e_last_q;
    end
  end

endmodule

// ===== src/flat_triangle_edge_span_setup.sv =====
// Top level of the flat triangle edge span setup block
//
// Command channel: a triangle transfers at a rising edge with start high
// and busy low. Configuration writes (tile origin x at index 0, y at
// index 1) land at any edge with cfg_we_i high; the user must make them
// only while the block is idle, which the block itself does not enforce.
// Each triangle produces ROWS (8) results, one per cycle on consecutive
// cycles, each marked by strobe_o for one cycle, lane 0 first.
// From transfer to the first result, a triangle passes through the queue,
// the two radix-16 slope dividers, the start value products and sums,
// the lane walk and the registered result stage. Sustained throughput is
// limited by the divider iterations and by the lane walk; the front end
// and a two-entry queue let new triangles transfer while one is walked.
// busy is high only while the queue is full.
// Reset clears the tile origins, the queue and all stage valid flags.
// The receiver cannot stall: results are shown once and not held.
module flat_triangle_edge_span_setup (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [ftes_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [ftes_pkg::XW-1:0]           cfg_data_i,
  input  logic                              start,
  output logic                              busy,
  input  logic                              opcode_i,
  input  logic signed [ftes_pkg::CW-1:0]    ax_i,
  input  logic signed [ftes_pkg::CW-1:0]    ay_i,
  input  logic signed [ftes_pkg::CW-1:0]    bx_i,
  input  logic signed [ftes_pkg::CW-1:0]    by_i,
  input  logic signed [ftes_pkg::CW-1:0]    cx_i,
  input  logic signed [ftes_pkg::CW-1:0]    cy_i,
  input  logic                              last_triangle_i,
  output logic                              strobe_o,
  output logic [ftes_pkg::LANE_W-1:0]       lane_o,
  output logic [ftes_pkg::XW-1:0]           left_x_o,
  output logic [ftes_pkg::XW-1:0]           right_x_o,
  output logic                              degenerate_o,
  output logic                              last_lane_o,
  output logic                              batch_done_o
);

  logic            push, pop, q_valid;
  ftes_pkg::item_t f_item, q_item;

  ftes_front u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .take_i (start && !busy),
    .opcode_i, .ax_i, .ay_i, .bx_i, .by_i, .cx_i, .cy_i, .last_triangle_i,
    .push_o (push),
    .item_o (f_item)
  );

  ftes_queue u_queue (
    .clk_i, .rst_ni,
    .push_i  (push),
    .item_i  (f_item),
    .pop_i   (pop),
    .full_o  (busy),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  ftes_back u_back (
    .clk_i, .rst_ni,
    .q_valid_i (q_valid),
    .q_item_i  (q_item),
    .pop_o     (pop),
    .strobe_o, .lane_o, .left_x_o, .right_x_o,
    .degenerate_o, .last_lane_o, .batch_done_o
  );

endmodule

// ===== src/ftes_checker.sv =====
// Port-level checks on the result channel, bound to the top level
`include "assert_macros.svh"

module ftes_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            strobe_o,
  input logic [ftes_pkg::LANE_W-1:0]     lane_o,
  input logic [ftes_pkg::XW-1:0]         left_x_o,
  input logic [ftes_pkg::XW-1:0]         right_x_o,
  input logic                            degenerate_o,
  input logic                            last_lane_o,
  input logic                            batch_done_o
);

  // Batch end only on a triangle's last lane
  `ASSERT_IMP(a_batch_on_last, clk_i, rst_ni, strobe_o && batch_done_o, last_lane_o)

  // Degenerate triangles give zero spans
  `ASSERT_IMP(a_degen_zero, clk_i, rst_ni, strobe_o && degenerate_o, (left_x_o == '0) && (right_x_o == '0))

  // Last lane carries the top lane index
  `ASSERT_IMP(a_last_index, clk_i, rst_ni, strobe_o && last_lane_o, lane_o == ftes_pkg::LANE_W'(ftes_pkg::ROWS - 1))

  // Lanes of one triangle follow back to back in order
  `ASSERT_NXT(a_lane_run, clk_i, rst_ni, strobe_o && !last_lane_o, strobe_o && (lane_o == ftes_pkg::LANE_W'($past(lane_o) + 1'b1)))

endmodule

bind flat_triangle_edge_span_setup ftes_checker u_ftes_checker (.*);
